// ===== hdl/ptns_pkg.sv =====
package ptns_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned COORD_W = 20;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned RAD_W   = 19;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned DIST_W  = SQ_W + 2;
  localparam int unsigned RING_W  = 2 * RAD_W;
  localparam int unsigned RND_W   = 32;
  localparam int unsigned BIT_W   = $clog2(RND_W);
  localparam int unsigned TRY_SHIFT = 2;

  localparam logic [DIST_W-1:0] NEAR_LIMIT = DIST_W'(64'd2560000000000);
  localparam logic [DIST_W-1:0] AT_LIMIT   = DIST_W'(64'd6400);
  localparam logic [RND_W-1:0]  LFSR_TAPS  = 32'h8020_0003;

  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_NEAREST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIND_AT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PICK    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_SLOT = 2'd3;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_NEAREST,
    OP_FIND_AT,
    OP_PICK,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [MASK_W-1:0]         mask;
  } entry_t;

  typedef struct packed {
    op_e              op;
    entry_t           pt;
    logic [RAD_W-1:0] lo;
    logic [RAD_W-1:0] hi;
    logic [IDX_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] slot;
    entry_t           ent;
    logic [CNT_W-1:0] held;
  } res_t;

  function automatic logic [RND_W-1:0] lfsr_next(input logic [RND_W-1:0] s);
    return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

// ===== hdl/ptns_front.sv =====
module ptns_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [ptns_pkg::ACT_W-1:0]           action_i,
  input  logic signed [ptns_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [ptns_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [ptns_pkg::COORD_W-1:0]  point_z_i,
  input  logic [ptns_pkg::MASK_W-1:0]          type_mask_i,
  input  logic [ptns_pkg::RAD_W-1:0]           min_distance_i,
  input  logic [ptns_pkg::RAD_W-1:0]           max_distance_i,
  input  logic [ptns_pkg::IDX_W-1:0]           slot_index_i,
  output logic                                 cmd_valid_o,
  input  logic                                 cmd_ready_i,
  output ptns_pkg::cmd_t                       cmd_o
);

  ptns_pkg::cmd_t fifo_q [2];
  ptns_pkg::cmd_t cmd_in;
  logic [1:0]     cnt_q;
  logic           wr_ptr_q, rd_ptr_q;
  logic           wr_en, rd_en;

  always_comb begin
    cmd_in.pt.x    = point_x_i;
    cmd_in.pt.y    = point_y_i;
    cmd_in.pt.z    = point_z_i;
    cmd_in.pt.mask = type_mask_i;
    cmd_in.lo      = min_distance_i;
    cmd_in.hi      = max_distance_i;
    cmd_in.sel     = slot_index_i;
    case (action_i)
      ptns_pkg::ACT_INSERT:  cmd_in.op = ptns_pkg::OP_INSERT;
      ptns_pkg::ACT_REMOVE:  cmd_in.op = ptns_pkg::OP_REMOVE;
      ptns_pkg::ACT_NEAREST: cmd_in.op = ptns_pkg::OP_NEAREST;
      ptns_pkg::ACT_FIND_AT: cmd_in.op = ptns_pkg::OP_FIND_AT;
      ptns_pkg::ACT_PICK:    cmd_in.op = ptns_pkg::OP_PICK;
      default:               cmd_in.op = ptns_pkg::OP_NONE;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/ptns_engine.sv =====
module ptns_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptns_pkg::RND_W-1:0]    cfg_wdata_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  ptns_pkg::cmd_t                cmd_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ptns_pkg::res_t                res_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RM_CAP,
    S_RM_SHIFT,
    S_SCAN,
    S_TRY_STEP,
    S_DIV,
    S_TRY_RD,
    S_TRY_WAIT,
    S_DONE
  } state_e;

  state_e                          state_q;
  ptns_pkg::cmd_t                  cmd_q;
  logic [ptns_pkg::CNT_W-1:0]      count_q, idx_q, tries_q, idx_inc;
  logic [ptns_pkg::RND_W-1:0]      lfsr_q, dv_q;
  logic [ptns_pkg::BIT_W-1:0]      bit_q;
  logic [ptns_pkg::IDX_W-1:0]      rem_q, wa_q;
  logic                            pend_q;
  logic [ptns_pkg::RING_W-1:0]     lo2_q, hi2_q;
  logic [ptns_pkg::DIST_W-1:0]     best_q;
  logic [ptns_pkg::ST_W-1:0]       st_q;
  logic [ptns_pkg::IDX_W-1:0]      slot_q;
  ptns_pkg::entry_t                ent_q;

  ptns_pkg::entry_t                mem_q [ptns_pkg::DEPTH];
  ptns_pkg::entry_t                rd_q, wd;
  logic                            rd_en, look, we;
  logic [ptns_pkg::IDX_W-1:0]      rd_addr, wa;

  logic                            v1_q, v2_q, v3_q;
  logic [ptns_pkg::IDX_W-1:0]      slot1_q, slot2_q, slot3_q;
  ptns_pkg::entry_t                ent2_q, ent3_q;
  logic [ptns_pkg::SQ_W-1:0]       sq2_q [3];
  logic [ptns_pkg::DIST_W-1:0]     d3_q;

  logic signed [ptns_pkg::DIFF_W-1:0] dx, dy, dz;
  logic signed [ptns_pkg::SQ_W-1:0]   sx, sy, sz;
  logic [ptns_pkg::DIST_W-1:0]        dsum;

  logic                            type_ok, ring_ok, match_hit, at_hit, near_better;
  logic                            first_hit, stop;
  logic [ptns_pkg::IDX_W:0]        div_r, div_s;
  logic                            div_ge, full_tbl;

  assign idx_inc  = idx_q + ptns_pkg::CNT_W'(1);
  assign full_tbl = (count_q == ptns_pkg::CNT_W'(ptns_pkg::DEPTH));

  // stage 3 checks
  assign type_ok     = (ent3_q.mask & cmd_q.pt.mask) == cmd_q.pt.mask;
  assign ring_ok     = (d3_q <= ptns_pkg::DIST_W'(hi2_q)) && (d3_q >= ptns_pkg::DIST_W'(lo2_q));
  assign match_hit   = type_ok && ring_ok;
  assign at_hit      = d3_q < ptns_pkg::AT_LIMIT;
  assign near_better = d3_q < best_q;
  assign first_hit   = (cmd_q.op == ptns_pkg::OP_FIND_AT) ? at_hit : match_hit;
  assign stop        = v3_q && (cmd_q.op != ptns_pkg::OP_NEAREST) && first_hit;

  // remainder step
  assign div_r  = {rem_q, dv_q[ptns_pkg::RND_W-1]};
  assign div_ge = div_r >= count_q;
  assign div_s  = div_r - count_q;

  always_comb begin
    rd_en   = 1'b0;
    look    = 1'b0;
    rd_addr = idx_q[ptns_pkg::IDX_W-1:0];
    case (state_q)
      S_DISPATCH: begin
        if (cmd_q.op == ptns_pkg::OP_REMOVE) begin
          rd_en   = 1'b1;
          rd_addr = cmd_q.sel;
        end
      end
      S_RM_SHIFT: begin
        if (idx_inc < count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[ptns_pkg::IDX_W-1:0];
        end
      end
      S_SCAN: begin
        if ((idx_q < count_q) && !stop) begin
          rd_en = 1'b1;
          look  = 1'b1;
        end
      end
      S_TRY_RD: begin
        rd_en   = 1'b1;
        look    = 1'b1;
        rd_addr = rem_q;
      end
      default: ;
    endcase
  end

  assign we = pend_q || ((state_q == S_DISPATCH) && (cmd_q.op == ptns_pkg::OP_INSERT) && !full_tbl);
  assign wa = pend_q ? wa_q : count_q[ptns_pkg::IDX_W-1:0];
  assign wd = pend_q ? rd_q : cmd_q.pt;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // distance pipeline
  assign dx   = ptns_pkg::DIFF_W'($signed(rd_q.x)) - ptns_pkg::DIFF_W'($signed(cmd_q.pt.x));
  assign dy   = ptns_pkg::DIFF_W'($signed(rd_q.y)) - ptns_pkg::DIFF_W'($signed(cmd_q.pt.y));
  assign dz   = ptns_pkg::DIFF_W'($signed(rd_q.z)) - ptns_pkg::DIFF_W'($signed(cmd_q.pt.z));
  assign sx   = dx * dx;
  assign sy   = dy * dy;
  assign sz   = dz * dz;
  assign dsum = ptns_pkg::DIST_W'(sq2_q[0]) + ptns_pkg::DIST_W'(sq2_q[1])
              + ptns_pkg::DIST_W'(sq2_q[2]);

  always_ff @(posedge clk_i) begin
    slot1_q  <= rd_addr;
    slot2_q  <= slot1_q;
    ent2_q   <= rd_q;
    sq2_q[0] <= ptns_pkg::SQ_W'(sx);
    sq2_q[1] <= ptns_pkg::SQ_W'(sy);
    sq2_q[2] <= ptns_pkg::SQ_W'(sz);
    slot3_q  <= slot2_q;
    ent3_q   <= ent2_q;
    d3_q     <= dsum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      count_q <= '0;
      idx_q   <= '0;
      tries_q <= '0;
      lfsr_q  <= ptns_pkg::RND_W'(1);
      dv_q    <= '0;
      bit_q   <= '0;
      rem_q   <= '0;
      wa_q    <= '0;
      pend_q  <= 1'b0;
      lo2_q   <= '0;
      hi2_q   <= '0;
      best_q  <= '0;
      st_q    <= ptns_pkg::ST_MISS;
      slot_q  <= '0;
      ent_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      v1_q   <= look;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      pend_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          best_q  <= ptns_pkg::NEAR_LIMIT;
          idx_q   <= '0;
          lo2_q   <= ptns_pkg::RING_W'(cmd_q.lo) * ptns_pkg::RING_W'(cmd_q.lo);
          hi2_q   <= ptns_pkg::RING_W'(cmd_q.hi) * ptns_pkg::RING_W'(cmd_q.hi);
          tries_q <= (count_q >> ptns_pkg::TRY_SHIFT) + ptns_pkg::CNT_W'(1);
          st_q    <= ptns_pkg::ST_MISS;
          slot_q  <= '0;
          ent_q   <= '0;
          state_q <= S_DONE;
          case (cmd_q.op)
            ptns_pkg::OP_INSERT: begin
              if (full_tbl) begin
                st_q <= ptns_pkg::ST_FULL;
              end else begin
                st_q    <= ptns_pkg::ST_OK;
                slot_q  <= count_q[ptns_pkg::IDX_W-1:0];
                ent_q   <= cmd_q.pt;
                count_q <= idx_inc - idx_q + count_q;
              end
            end
            ptns_pkg::OP_REMOVE: begin
              if ({1'b0, cmd_q.sel} >= count_q) begin
                st_q <= ptns_pkg::ST_BAD_SLOT;
              end else begin
                state_q <= S_RM_CAP;
              end
            end
            ptns_pkg::OP_NEAREST, ptns_pkg::OP_FIND_AT: begin
              state_q <= S_SCAN;
            end
            ptns_pkg::OP_PICK: begin
              if (count_q != '0) begin
                state_q <= S_TRY_STEP;
              end
            end
            default: ;
          endcase
        end
        S_RM_CAP: begin
          st_q    <= ptns_pkg::ST_OK;
          slot_q  <= cmd_q.sel;
          ent_q   <= rd_q;
          idx_q   <= {1'b0, cmd_q.sel};
          state_q <= S_RM_SHIFT;
        end
        S_RM_SHIFT: begin
          if (rd_en) begin
            pend_q <= 1'b1;
            wa_q   <= idx_q[ptns_pkg::IDX_W-1:0];
            idx_q  <= idx_inc;
          end else if (!pend_q) begin
            count_q <= count_q - ptns_pkg::CNT_W'(1);
            state_q <= S_DONE;
          end
        end
        S_SCAN: begin
          if (look) begin
            idx_q <= idx_inc;
          end
          if (v3_q) begin
            if (cmd_q.op == ptns_pkg::OP_NEAREST) begin
              if (near_better) begin
                best_q <= d3_q;
                st_q   <= ptns_pkg::ST_OK;
                slot_q <= slot3_q;
                ent_q  <= ent3_q;
              end
            end else if (first_hit) begin
              st_q    <= ptns_pkg::ST_OK;
              slot_q  <= slot3_q;
              ent_q   <= ent3_q;
              v1_q    <= 1'b0;
              v2_q    <= 1'b0;
              state_q <= S_DONE;
            end
          end
          if (!look && !v1_q && !v2_q && !v3_q) begin
            state_q <= S_DONE;
          end
        end
        S_TRY_STEP: begin
          lfsr_q  <= ptns_pkg::lfsr_next(lfsr_q);
          dv_q    <= ptns_pkg::lfsr_next(lfsr_q);
          rem_q   <= '0;
          bit_q   <= ptns_pkg::BIT_W'(ptns_pkg::RND_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= div_ge ? div_s[ptns_pkg::IDX_W-1:0] : div_r[ptns_pkg::IDX_W-1:0];
          dv_q  <= dv_q << 1;
          bit_q <= bit_q - ptns_pkg::BIT_W'(1);
          if (bit_q == '0) begin
            state_q <= S_TRY_RD;
          end
        end
        S_TRY_RD: begin
          state_q <= S_TRY_WAIT;
        end
        S_TRY_WAIT: begin
          if (v3_q) begin
            if (match_hit) begin
              st_q    <= ptns_pkg::ST_OK;
              slot_q  <= slot3_q;
              ent_q   <= ent3_q;
              state_q <= S_DONE;
            end else if (tries_q == ptns_pkg::CNT_W'(1)) begin
              idx_q   <= '0;
              state_q <= S_SCAN;
            end else begin
              tries_q <= tries_q - ptns_pkg::CNT_W'(1);
              state_q <= S_TRY_STEP;
            end
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        lfsr_q <= (cfg_wdata_i == '0) ? ptns_pkg::RND_W'(1) : cfg_wdata_i;
      end
    end
  end

  assign cmd_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.status = st_q;
  assign res_o.slot   = slot_q;
  assign res_o.ent    = ent_q;
  assign res_o.held   = count_q;

endmodule

// ===== hdl/point_table_nearest_and_range_search.sv =====
// Table of up to 256 points (x, y, z, type bits) in insertion order, with insert, remove,
// nearest, find-at and random-pick actions; one result per item. A two-deep command queue
// takes items while the search engine works, and a one-entry result register holds the
// finished result. Insert and bad actions finish in the dispatch state; remove moves each
// later entry down one slot (one memory read and write per moved entry); nearest and
// find-at read one entry per cycle into a three-stage distance pipeline;
// random pick draws one slot per try from the 32-bit LFSR word by bit-serial remainder,
// up to n/4 + 1 tries with n entries held, then scans for a match. A zero seed loads as 1.
module point_table_nearest_and_range_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [ptns_pkg::ACT_W-1:0]           action_i,
  input  logic signed [ptns_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [ptns_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [ptns_pkg::COORD_W-1:0]  point_z_i,
  input  logic [ptns_pkg::MASK_W-1:0]          type_mask_i,
  input  logic [ptns_pkg::RAD_W-1:0]           min_distance_i,
  input  logic [ptns_pkg::RAD_W-1:0]           max_distance_i,
  input  logic [ptns_pkg::IDX_W-1:0]           slot_index_i,
  input  logic                                 cfg_we_i,
  input  logic [ptns_pkg::RND_W-1:0]           cfg_wdata_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [ptns_pkg::ST_W-1:0]            status_o,
  output logic [ptns_pkg::IDX_W-1:0]           found_slot_o,
  output logic signed [ptns_pkg::COORD_W-1:0]  found_x_o,
  output logic signed [ptns_pkg::COORD_W-1:0]  found_y_o,
  output logic signed [ptns_pkg::COORD_W-1:0]  found_z_o,
  output logic [ptns_pkg::MASK_W-1:0]          found_type_mask_o,
  output logic [ptns_pkg::CNT_W-1:0]           entries_held_o
);

  logic           cmd_valid, cmd_ready;
  ptns_pkg::cmd_t cmd;
  logic           eng_valid, eng_ready;
  ptns_pkg::res_t eng_res, out_q;
  logic           out_valid_q;

  ptns_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .type_mask_i    (type_mask_i),
    .min_distance_i (min_distance_i),
    .max_distance_i (max_distance_i),
    .slot_index_i   (slot_index_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  ptns_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (eng_valid),
    .res_ready_i (eng_ready),
    .res_o       (eng_res)
  );

  assign eng_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i) begin
    if (eng_valid && eng_ready) begin
      out_q <= eng_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_valid && eng_ready) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty             = !out_valid_q;
  assign status_o          = out_q.status;
  assign found_slot_o      = out_q.slot;
  assign found_x_o         = out_q.ent.x;
  assign found_y_o         = out_q.ent.y;
  assign found_z_o         = out_q.ent.z;
  assign found_type_mask_o = out_q.ent.mask;
  assign entries_held_o    = out_q.held;

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> entries_held_o <= ptns_pkg::CNT_W'(ptns_pkg::DEPTH))
    else $error("entry count out of range");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ptns_pkg::ST_OK) |-> (found_slot_o == '0 && found_type_mask_o == '0))
    else $error("found fields set on a miss");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eng_valid && eng_ready) |=> !empty)
    else $error("result transfer lost");

endmodule
